### rtl/dvrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants for the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int ROUTE_ENTRIES_DEF = 16;
  localparam int CHILD_ENTRIES_DEF = 16;

  localparam logic signed [15:0] HOP_MAX         = 16'sh7FFF;
  localparam logic signed [15:0] HOP_UNREACHABLE = -16'sd1;
  localparam logic [30:0]        OWN_SEQ_RESET   = 31'd2;

  // Item function codes
  localparam logic [1:0] FUNC_ADVERTISE = 2'd0;
  localparam logic [1:0] FUNC_CHILD_MAP = 2'd1;
  localparam logic [1:0] FUNC_NEXT_HOP  = 2'd2;
  localparam logic [1:0] FUNC_REACH     = 2'd3;

  // Register index, taken from paddr[2]
  localparam logic REG_MY_ADDRESS     = 1'b0;
  localparam logic REG_PARENT_ADDRESS = 1'b1;

  typedef struct packed {
    logic [31:0]        key;
    logic [31:0]        next_hop;
    logic signed [15:0] hops;
    logic [30:0]        seq;
  } route_entry_t;

  typedef struct packed {
    logic [31:0] ap;
    logic [31:0] station;
  } child_entry_t;

endpackage : dvrt_pkg
`default_nettype wire

### rtl/dvrt_route_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvrt_route_mem
// Route entry store: one write port, one registered read port, valid bits.
// ----------------------------------------------------------------------------
module dvrt_route_mem
  import dvrt_pkg::*;
#(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
  localparam int AW = $clog2(ROUTE_ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire route_entry_t  wdata,
  input  wire logic [AW-1:0] raddr,
  output route_entry_t       rdata_r,
  output logic               rvalid_r
);

  route_entry_t mem [ROUTE_ENTRIES];
  logic [ROUTE_ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

endmodule : dvrt_route_mem
`default_nettype wire

### rtl/dvrt_child_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvrt_child_mem
// Child map store: one write port, one registered read port, valid bits.
// ----------------------------------------------------------------------------
module dvrt_child_mem
  import dvrt_pkg::*;
#(
  parameter int CHILD_ENTRIES = CHILD_ENTRIES_DEF,
  localparam int AW = (CHILD_ENTRIES > 1) ? $clog2(CHILD_ENTRIES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire child_entry_t  wdata,
  input  wire logic [AW-1:0] raddr,
  output child_entry_t       rdata_r,
  output logic               rvalid_r
);

  child_entry_t mem [CHILD_ENTRIES];
  logic [CHILD_ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

endmodule : dvrt_child_mem
`default_nettype wire

### rtl/distance_vector_route_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Sequence-numbered distance-vector route table with a child address map.
// ----------------------------------------------------------------------------
// Flow: each table scan reads every entry of that table in turn. Advertise, child
//   map and reachability scan one table; next hop checks the parent address, then
//   scans the child map, the route table and, on a route hit, the child map again.
// Throughput: one item at a time; a new item is taken once the last one has
//   moved to the output register. Scan rate is set by one memory read port.
// Reset: valid bits, own sequence (two), addresses (zero) and control clear.
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
  parameter int CHILD_ENTRIES = CHILD_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input item channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic [31:0]        in_node_address,
  input  wire logic signed [15:0] in_hop_distance,
  input  wire logic [30:0]        in_sequence_number,
  input  wire logic [31:0]        in_sender_address,
  input  wire logic [31:0]        in_station_address,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_changed,
  output logic                    out_route_found,
  output logic [31:0]             out_next_hop_address,
  output logic                    out_reachable,
  output logic                    out_table_full,
  output logic [30:0]             out_own_sequence_out,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int RW = $clog2(ROUTE_ENTRIES);
  localparam int CW = (CHILD_ENTRIES > 1) ? $clog2(CHILD_ENTRIES) : 1;
  localparam int IW = (RW > CW) ? RW : CW;
  localparam logic [IW-1:0] ROUTE_LAST = IW'(ROUTE_ENTRIES - 1);
  localparam logic [IW-1:0] CHILD_LAST = IW'(CHILD_ENTRIES - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  // which search is running
  localparam logic [1:0] P_ROUTE  = 2'd0;
  localparam logic [1:0] P_CHILD  = 2'd1;
  localparam logic [1:0] P_XLATE  = 2'd2;
  localparam logic [1:0] P_PARENT = 2'd3;

  // ---------------------------------------------------------------- config
  logic [31:0] my_addr_r, parent_addr_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_PARENT_ADDRESS) ? parent_addr_r : my_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_addr_r     <= '0;
      parent_addr_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MY_ADDRESS) begin
        my_addr_r <= pwdata;
      end else begin
        parent_addr_r <= pwdata;
      end
    end
  end

  // ---------------------------------------------------------------- state
  logic [1:0]         state_r, state_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [1:0]         func_r;
  logic [31:0]        node_r, sender_r, station_r;
  logic signed [15:0] hop_r;
  logic [30:0]        seq_r;
  logic [30:0]        own_seq_r, own_seq_nxt;
  logic [31:0]        key_r, key_nxt;

  // scan engine
  logic [IW-1:0] idx_r, pipe_idx_r, hit_idx_r, free_idx_r;
  logic          issue_done_r, pipe_v_r, hit_r, free_found_r;
  logic          scan_start;
  route_entry_t  hit_route_r;
  logic [31:0]   hit_station_r;

  // pending result
  logic        res_changed_r, res_found_r, res_reach_r, res_full_r;
  logic [31:0] res_nh_r;
  logic        res_changed_nxt, res_found_nxt, res_reach_nxt, res_full_nxt;
  logic [31:0] res_nh_nxt;

  // output register
  logic        out_valid_r;
  logic        o_changed_r, o_found_r, o_reach_r, o_full_r;
  logic [31:0] o_nh_r;
  logic [30:0] o_own_r;

  // memories
  route_entry_t r_wdata, r_rdata;
  child_entry_t c_wdata, c_rdata;
  logic         r_we, c_we, r_rvalid, c_rvalid;

  logic accept;
  logic is_route_scan;
  logic [IW-1:0] scan_last;
  logic match, scan_end;

  assign accept        = in_valid && !in_stall;
  assign in_stall      = (state_r != S_IDLE);
  assign is_route_scan = (phase_r == P_ROUTE);
  assign scan_last     = is_route_scan ? ROUTE_LAST : CHILD_LAST;
  assign match         = is_route_scan ? (r_rvalid && r_rdata.key == key_r)
                                       : (c_rvalid && c_rdata.ap == key_r);
  assign scan_end      = (state_r == S_SCAN) && pipe_v_r && (pipe_idx_r == scan_last);

  dvrt_route_mem #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_route (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (r_we),
    .waddr    (hit_r ? hit_idx_r[RW-1:0] : free_idx_r[RW-1:0]),
    .wdata    (r_wdata),
    .raddr    (idx_r[RW-1:0]),
    .rdata_r  (r_rdata),
    .rvalid_r (r_rvalid)
  );

  dvrt_child_mem #(.CHILD_ENTRIES(CHILD_ENTRIES)) u_child (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (c_we),
    .waddr    (hit_r ? hit_idx_r[CW-1:0] : free_idx_r[CW-1:0]),
    .wdata    (c_wdata),
    .raddr    (idx_r[CW-1:0]),
    .rdata_r  (c_rdata),
    .rvalid_r (c_rvalid)
  );

  // hop arithmetic: plain increment for the shorter-path test, saturating
  // increment (skipped on odd sequence) for stored hops
  logic signed [16:0] hop_inc;
  logic signed [15:0] hop_store;
  logic               seq_newer, seq_equal, path_shorter;

  assign hop_inc      = 17'(signed'({hop_r[15], hop_r}) + 17'sd1);
  assign hop_store    = seq_r[0] ? hop_r : ((hop_r == HOP_MAX) ? HOP_MAX : hop_inc[15:0]);
  assign seq_newer    = seq_r > hit_route_r.seq;
  assign seq_equal    = seq_r == hit_route_r.seq;
  assign path_shorter = hop_inc < signed'({hit_route_r.hops[15], hit_route_r.hops});

  // ------------------------------------------------------- decide / sequence
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    key_nxt         = key_r;
    own_seq_nxt     = own_seq_r;
    scan_start      = 1'b0;
    r_we            = 1'b0;
    c_we            = 1'b0;
    r_wdata         = '{key: node_r, next_hop: sender_r, hops: hop_store, seq: seq_r};
    c_wdata         = '{ap: node_r, station: station_r};
    res_changed_nxt = res_changed_r;
    res_found_nxt   = res_found_r;
    res_reach_nxt   = res_reach_r;
    res_full_nxt    = res_full_r;
    res_nh_nxt      = res_nh_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_changed_nxt = 1'b0;
          res_found_nxt   = 1'b0;
          res_reach_nxt   = 1'b0;
          res_full_nxt    = 1'b0;
          res_nh_nxt      = '0;
          key_nxt         = in_node_address;
          unique case (in_func)
            FUNC_NEXT_HOP: begin
              phase_nxt = P_PARENT;
              state_nxt = S_DECIDE;
            end
            FUNC_CHILD_MAP: begin
              phase_nxt  = P_CHILD;
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end
            default: begin
              phase_nxt  = P_ROUTE;
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        unique case (func_r)
          FUNC_ADVERTISE: begin
            if (node_r == my_addr_r && seq_r > own_seq_r) begin
              own_seq_nxt = seq_r;
            end
            if (!hit_r) begin
              if (free_found_r) begin
                r_we            = 1'b1;
                res_changed_nxt = 1'b1;
              end else begin
                res_full_nxt = 1'b1;
              end
            end else if (seq_newer) begin
              r_we            = 1'b1;
              res_changed_nxt = 1'b1;
            end else if (seq_equal && path_shorter) begin
              r_wdata.hops    = hop_inc[15:0];
              r_we            = 1'b1;
              res_changed_nxt = 1'b1;
            end
          end
          FUNC_CHILD_MAP: begin
            if (hit_r || free_found_r) begin
              c_we = 1'b1;
            end else begin
              res_full_nxt = 1'b1;
            end
          end
          FUNC_NEXT_HOP: begin
            unique case (phase_r)
              P_PARENT: begin
                if (node_r == parent_addr_r) begin
                  res_found_nxt = 1'b1;
                  res_nh_nxt    = parent_addr_r;
                end else begin
                  phase_nxt  = P_CHILD;
                  scan_start = 1'b1;
                  state_nxt  = S_SCAN;
                end
              end
              P_CHILD: begin
                if (hit_r) begin
                  res_found_nxt = 1'b1;
                  res_nh_nxt    = hit_station_r;
                end else begin
                  phase_nxt  = P_ROUTE;
                  scan_start = 1'b1;
                  state_nxt  = S_SCAN;
                end
              end
              P_ROUTE: begin
                if (hit_r) begin
                  // translate the route's next hop through the child map
                  res_found_nxt = 1'b1;
                  res_nh_nxt    = hit_route_r.next_hop;
                  key_nxt       = hit_route_r.next_hop;
                  phase_nxt     = P_XLATE;
                  scan_start    = 1'b1;
                  state_nxt     = S_SCAN;
                end
              end
              default: begin
                if (hit_r) begin
                  res_nh_nxt = hit_station_r;
                end
              end
            endcase
          end
          default: begin
            res_reach_nxt = hit_r && (hit_route_r.hops != HOP_UNREACHABLE)
                            && !hit_route_r.seq[0];
          end
        endcase
      end
      default: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= P_ROUTE;
      own_seq_r    <= OWN_SEQ_RESET;
      issue_done_r <= 1'b0;
      pipe_v_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      own_seq_r <= own_seq_nxt;

      // scan engine: issue one read a cycle, compare the registered data in the next cycle
      if (scan_start) begin
        issue_done_r <= 1'b0;
        pipe_v_r     <= 1'b0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        pipe_v_r <= !issue_done_r;
        if (!issue_done_r && idx_r == scan_last) begin
          issue_done_r <= 1'b1;
        end
        if (pipe_v_r) begin
          if (match && !hit_r) begin
            hit_r <= 1'b1;
          end
          if (!free_found_r && !(is_route_scan ? r_rvalid : c_rvalid)) begin
            free_found_r <= 1'b1;
          end
        end
      end

      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    res_changed_r <= res_changed_nxt;
    res_found_r   <= res_found_nxt;
    res_reach_r   <= res_reach_nxt;
    res_full_r    <= res_full_nxt;
    res_nh_r      <= res_nh_nxt;

    if (accept) begin
      func_r    <= in_func;
      node_r    <= in_node_address;
      hop_r     <= in_hop_distance;
      seq_r     <= in_sequence_number;
      sender_r  <= in_sender_address;
      station_r <= in_station_address;
    end

    if (scan_start) begin
      idx_r <= '0;
    end else if (state_r == S_SCAN && !issue_done_r) begin
      idx_r      <= idx_r + IW'(1);
      pipe_idx_r <= idx_r;
    end

    // capture the first matching entry and the lowest free slot
    if (state_r == S_SCAN && pipe_v_r) begin
      if (match && !hit_r) begin
        hit_idx_r     <= pipe_idx_r;
        hit_route_r   <= r_rdata;
        hit_station_r <= c_rdata.station;
      end
      if (!free_found_r && !(is_route_scan ? r_rvalid : c_rvalid)) begin
        free_idx_r <= pipe_idx_r;
      end
    end

    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      o_changed_r <= res_changed_r;
      o_found_r   <= res_found_r;
      o_reach_r   <= res_reach_r;
      o_full_r    <= res_full_r;
      o_nh_r      <= res_nh_r;
      o_own_r     <= own_seq_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_changed          = o_changed_r;
  assign out_route_found      = o_found_r;
  assign out_next_hop_address = o_nh_r;
  assign out_reachable        = o_reach_r;
  assign out_table_full       = o_full_r;
  assign out_own_sequence_out = o_own_r;

endmodule : distance_vector_route_table
`default_nettype wire

### tb/dvrt_checker.sv
// ----------------------------------------------------------------------------
// dvrt_checker
// Watches the item, result and register ports of the route table, keeps a
// shadow copy of the tables and compares each result in arrival order.
// ----------------------------------------------------------------------------
module dvrt_checker
  import dvrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [31:0]        in_node_address,
  input  logic signed [15:0] in_hop_distance,
  input  logic [30:0]        in_sequence_number,
  input  logic [31:0]        in_sender_address,
  input  logic [31:0]        in_station_address,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_changed,
  input  logic               out_route_found,
  input  logic [31:0]        out_next_hop_address,
  input  logic               out_reachable,
  input  logic               out_table_full,
  input  logic [30:0]        out_own_sequence_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending,
  output int                 items_taken,
  output int                 results_seen,
  output int                 drops_seen,
  output int                 hops_found
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NR = ROUTE_ENTRIES_DEF;
  localparam int NC = CHILD_ENTRIES_DEF;

  typedef struct packed {
    logic        changed;
    logic        found;
    logic [31:0] next_hop;
    logic        reach;
    logic        full;
    logic [30:0] own_seq;
  } route_result_t;

  logic [31:0]        shadow_my, shadow_parent;
  logic               rt_valid [NR];
  logic [31:0]        rt_key   [NR];
  logic [31:0]        rt_next  [NR];
  logic signed [15:0] rt_hops  [NR];
  logic [30:0]        rt_seq   [NR];
  logic               ch_valid [NC];
  logic [31:0]        ch_ap    [NC];
  logic [31:0]        ch_sta   [NC];
  logic [30:0]        own_seq;

  route_result_t expected_results[$];

  function automatic int find_route(logic [31:0] key);
    for (int i = 0; i < NR; i++)
      if (rt_valid[i] && rt_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_child(logic [31:0] key);
    for (int i = 0; i < NC; i++)
      if (ch_valid[i] && ch_ap[i] == key) return i;
    return -1;
  endfunction

  function automatic logic signed [15:0] bump_hops(logic signed [15:0] h, logic [30:0] s);
    if (s[0]) return h;
    if (h == HOP_MAX) return HOP_MAX;
    return h + 16'sd1;
  endfunction

  // Apply one item to the shadow tables and return the result it should give.
  function automatic route_result_t apply_route_item(
      logic [1:0] fn, logic [31:0] node, logic signed [15:0] hop,
      logic [30:0] seq, logic [31:0] sender, logic [31:0] station);
    route_result_t res;
    int r, c, slot;
    res = '0;
    slot = -1;
    case (fn)
      FUNC_ADVERTISE: begin
        r = find_route(node);
        if (node == shadow_my && seq > own_seq) own_seq = seq;
        if (r < 0) begin
          for (int i = NR - 1; i >= 0; i--) if (!rt_valid[i]) slot = i;
          if (slot >= 0) begin
            rt_valid[slot] = 1'b1;
            rt_key[slot]   = node;
            rt_next[slot]  = sender;
            rt_hops[slot]  = bump_hops(hop, seq);
            rt_seq[slot]   = seq;
            res.changed    = 1'b1;
          end else begin
            res.full = 1'b1;
          end
        end else if (seq > rt_seq[r]) begin
          rt_next[r]  = sender;
          rt_hops[r]  = bump_hops(hop, seq);
          rt_seq[r]   = seq;
          res.changed = 1'b1;
        end else if (seq == rt_seq[r] && (int'(hop) + 1) < int'(rt_hops[r])) begin
          // equal sequence, shorter path: plain +1, never saturates here
          rt_next[r]  = sender;
          rt_hops[r]  = hop + 16'sd1;
          res.changed = 1'b1;
        end
      end
      FUNC_CHILD_MAP: begin
        c = find_child(node);
        if (c >= 0) begin
          ch_sta[c] = station;
        end else begin
          for (int i = NC - 1; i >= 0; i--) if (!ch_valid[i]) slot = i;
          if (slot >= 0) begin
            ch_valid[slot] = 1'b1;
            ch_ap[slot]    = node;
            ch_sta[slot]   = station;
          end else begin
            res.full = 1'b1;
          end
        end
      end
      FUNC_NEXT_HOP: begin
        if (node == shadow_parent) begin
          res.found    = 1'b1;
          res.next_hop = shadow_parent;
        end else if (find_child(node) >= 0) begin
          res.found    = 1'b1;
          res.next_hop = ch_sta[find_child(node)];
        end else begin
          r = find_route(node);
          if (r >= 0) begin
            res.found    = 1'b1;
            c            = find_child(rt_next[r]);
            res.next_hop = (c >= 0) ? ch_sta[c] : rt_next[r];
          end
        end
      end
      default: begin
        r = find_route(node);
        res.reach = (r >= 0) && rt_hops[r] != HOP_UNREACHABLE && !rt_seq[r][0];
      end
    endcase
    res.own_seq = own_seq;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    route_result_t want;
    if (!rst_n) begin
      shadow_my     = '0;
      shadow_parent = '0;
      own_seq       = OWN_SEQ_RESET;
      for (int i = 0; i < NR; i++) rt_valid[i] = 1'b0;
      for (int i = 0; i < NC; i++) ch_valid[i] = 1'b0;
      expected_results.delete();
      errors = 0; items_taken = 0; results_seen = 0; drops_seen = 0; hops_found = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MY_ADDRESS) shadow_my = pwdata;
        else shadow_parent = pwdata;
      end
      if (in_valid && !in_stall) begin
        want = apply_route_item(in_func, in_node_address, in_hop_distance,
                                in_sequence_number, in_sender_address, in_station_address);
        expected_results.push_back(want);
        items_taken++;
        if (want.full) drops_seen++;
        if (want.found) hops_found++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'd1, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_changed !== want.changed)
            report_mismatch("changed", out_changed, want.changed);
          if (out_route_found !== want.found)
            report_mismatch("route_found", out_route_found, want.found);
          if (out_next_hop_address !== want.next_hop)
            report_mismatch("next_hop_address", out_next_hop_address, want.next_hop);
          if (out_reachable !== want.reach)
            report_mismatch("reachable", out_reachable, want.reach);
          if (out_table_full !== want.full)
            report_mismatch("table_full", out_table_full, want.full);
          if (out_own_sequence_out !== want.own_seq)
            report_mismatch("own_sequence_out", out_own_sequence_out, want.own_seq);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### tb/tb_distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// tb_distance_vector_route_table
// Drives advertisements, child mappings, next hop lookups and reachability
// queries into the route table under several address settings and idle
// patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_table
  import dvrt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int PHASES         = 4;
  localparam int SETTLE_CYCLES  = 120;  // above the worst next hop scan
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;

  logic               clk, rst_n;
  logic               in_valid, in_stall;
  logic [1:0]         in_func;
  logic [31:0]        in_node_address;
  logic signed [15:0] in_hop_distance;
  logic [30:0]        in_sequence_number;
  logic [31:0]        in_sender_address, in_station_address;
  logic               out_valid, out_stall;
  logic               out_changed, out_route_found, out_reachable, out_table_full;
  logic [31:0]        out_next_hop_address;
  logic [30:0]        out_own_sequence_out;
  logic               psel, penable, pwrite, pready;
  logic [2:0]         paddr;
  logic [31:0]        pwdata, prdata;

  int errors, pending, items_taken, results_seen, drops_seen, hops_found;
  int idle_pct, stall_pct;
  logic hold_req, hold_done;
  int quiet_cycles;
  logic [31:0] addr_pool [24];

  distance_vector_route_table dut (.*);

  dvrt_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stall at the phase rate, plus one long hold-off on request.
  initial begin
    int held;
    out_stall = 1'b0;
    hold_done = 1'b0;
    held      = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        held++;
        if (held >= LONG_HOLD) hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves anything.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Write one register: setup cycle, then access cycle.
  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one item, hold it until taken, then maybe go idle for a while.
  task automatic send_item(logic [1:0] fn, logic [31:0] node, logic signed [15:0] hop,
                           logic [30:0] seq, logic [31:0] sender, logic [31:0] station);
    int gap;
    in_valid           <= 1'b1;
    in_func            <= fn;
    in_node_address    <= node;
    in_hop_distance    <= hop;
    in_sequence_number <= seq;
    in_sender_address  <= sender;
    in_station_address <= station;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap - 1) @(posedge clk);
      @(posedge clk);
    end
  endtask

  // Drain every outstanding result, then let any scan in flight settle.
  task automatic drain_and_settle();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_address();
    if ($urandom_range(99) < 85) return addr_pool[$urandom_range(23)];
    return $urandom();
  endfunction

  function automatic logic signed [15:0] pick_hops();
    case ($urandom_range(9))
      0: return HOP_UNREACHABLE;
      1: return HOP_MAX;
      2: return HOP_MAX - 16'sd1;
      3, 4: return 16'($urandom());
      default: return 16'($urandom_range(12));
    endcase
  endfunction

  function automatic logic [30:0] pick_sequence();
    case ($urandom_range(9))
      0: return 31'h7FFF_FFFF;
      1, 2: return 31'($urandom());
      default: return 31'($urandom_range(12));
    endcase
  endfunction

  task automatic send_random_item();
    int roll;
    logic [1:0] fn;
    roll = $urandom_range(99);
    // advertisements dominate; lookups and queries exercise what they built
    if (roll < 40)      fn = FUNC_ADVERTISE;
    else if (roll < 55) fn = FUNC_CHILD_MAP;
    else if (roll < 80) fn = FUNC_NEXT_HOP;
    else                fn = FUNC_REACH;
    send_item(fn, pick_address(), pick_hops(), pick_sequence(), pick_address(),
              ($urandom_range(3) == 0) ? $urandom() : pick_address());
  endtask

  initial begin
    logic [31:0] a, b, c, d;
    rst_n = 1'b0;
    in_valid = 1'b0; in_func = FUNC_ADVERTISE; in_node_address = '0;
    in_hop_distance = '0; in_sequence_number = '0;
    in_sender_address = '0; in_station_address = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_req = 1'b0;
    idle_pct = 0; stall_pct = 0;
    // small address pool so keys collide, tables fill and children translate
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 24; i++) addr_pool[i] = $urandom();
    a = addr_pool[2]; b = addr_pool[3]; c = addr_pool[4]; d = addr_pool[5];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: every function and each corner of the update rules.
    write_reg(REG_MY_ADDRESS, d);
    write_reg(REG_PARENT_ADDRESS, addr_pool[6]);
    send_item(FUNC_ADVERTISE, a, 16'sd3, 31'd4, b, 0);        // insert new route
    send_item(FUNC_ADVERTISE, a, 16'sd1, 31'd4, c, 0);        // equal seq, shorter
    send_item(FUNC_ADVERTISE, a, 16'sd5, 31'd4, b, 0);        // equal seq, longer: keep
    send_item(FUNC_ADVERTISE, a, 16'sd9, 31'd6, b, 0);        // newer seq replaces
    send_item(FUNC_ADVERTISE, a, 16'sd2, 31'd5, b, 0);        // older seq: keep
    send_item(FUNC_ADVERTISE, b, HOP_MAX, 31'd8, c, 0);       // saturate hops
    send_item(FUNC_ADVERTISE, c, HOP_UNREACHABLE, 31'd9, a, 0); // odd seq, hops kept
    send_item(FUNC_REACH, a, 0, 0, 0, 0);
    send_item(FUNC_REACH, c, 0, 0, 0, 0);                     // odd seq: unreachable
    send_item(FUNC_REACH, addr_pool[7], 0, 0, 0, 0);          // no entry
    send_item(FUNC_ADVERTISE, d, 16'sd0, 31'h7FFF_FFFF, a, 0); // own seq adopted
    send_item(FUNC_ADVERTISE, d, 16'sd0, 31'd10, a, 0);       // lower own seq ignored
    send_item(FUNC_CHILD_MAP, b, 0, 0, 0, 32'h1234_5678);     // new child
    send_item(FUNC_CHILD_MAP, b, 0, 0, 0, 32'hFFFF_FFFF);     // update child
    send_item(FUNC_NEXT_HOP, addr_pool[6], 0, 0, 0, 0);       // parent match
    send_item(FUNC_NEXT_HOP, b, 0, 0, 0, 0);                  // child match
    send_item(FUNC_ADVERTISE, addr_pool[8], 16'sd0, 31'd2, b, 0);
    send_item(FUNC_NEXT_HOP, addr_pool[8], 0, 0, 0, 0);       // route via child
    send_item(FUNC_NEXT_HOP, a, 0, 0, 0, 0);                  // route via child as well
    send_item(FUNC_NEXT_HOP, addr_pool[9], 0, 0, 0, 0);       // miss
    drain_and_settle();

    // Random part: one phase per idle pattern, each under new addresses.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MY_ADDRESS, 32'h0);
          write_reg(REG_PARENT_ADDRESS, 32'h0);
        end
        1: begin
          write_reg(REG_MY_ADDRESS, 32'hFFFF_FFFF);
          write_reg(REG_PARENT_ADDRESS, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(REG_MY_ADDRESS, addr_pool[10]);
          write_reg(REG_PARENT_ADDRESS, addr_pool[11]);
        end
        default: begin
          write_reg(REG_MY_ADDRESS, $urandom());
          write_reg(REG_PARENT_ADDRESS, $urandom());
        end
      endcase
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // long receiver hold-off early in the first phase: backs up the block
        if (ph == 0 && n == 20) hold_req <= 1'b1;
        send_random_item();
      end
      drain_and_settle();
    end

    $display("covered %0d items and %0d results; %0d dropped inserts, %0d next hops found",
             items_taken, results_seen, drops_seen, hops_found);
    $display("address settings: zero, all ones, pool and random; four idle patterns");
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
